FILE: hw/rtl/drfi_pkg.sv
// Shared types and constants for the DRAM retention fault injector.
// Used by drfi_ctrl, drfi_datapath and the top level. No dependencies.
`default_nettype none

package drfi_pkg;

   localparam int ADDR_W  = 10;
   localparam int TIME_W  = 48;
   localparam int DATA_W  = 64;
   localparam int DECAY_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic ACT_STORE = 1'b0;
   localparam logic ACT_LOAD  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_REFRESH_PERIOD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_OFFSET     = 2'd2;

   localparam logic [DECAY_W-1:0] REFRESH_PERIOD_RST  = 32'd64000000;
   localparam logic [DECAY_W-1:0] DECAY_THRESHOLD_RST = 32'd32000000;
   localparam logic [TIME_W-1:0]  TIME_OFFSET_RST     = 48'd0;

   typedef struct packed {
      logic clear_wr;
      logic latch;
      logic red_mul;
      logic red_prod;
      logic red_fix;
      logic red_row;
      logic store_wr;
      logic walk_issue;
      logic respond;
   } dp_cmd_type;

endpackage

`default_nettype wire

FILE: hw/rtl/drfi_ctrl.sv
// Sequencer for the DRAM retention fault injector: clearing pass, address
// reduction, row walk and result. Depends on drfi_pkg.
`default_nettype none

module drfi_ctrl
   import drfi_pkg::*;
#(
   parameter int CELL_COUNT    = 1024,
   parameter int CELLS_PER_ROW = 16,
   localparam int CNT_MAX = (CELL_COUNT > CELLS_PER_ROW) ? CELL_COUNT : CELLS_PER_ROW,
   localparam int CNT_W   = $clog2(CNT_MAX)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output dp_cmd_type            cmd,
   output logic [CNT_W-1:0]      step_idx
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MUL_C,
      S_PROD_C,
      S_FIX_C,
      S_MUL_R,
      S_PROD_R,
      S_FIX_R,
      S_WALK,
      S_DRAIN1,
      S_DRAIN2,
      S_RESULT
   } state_type;

   localparam logic [CNT_W-1:0] CLEAR_LAST = CNT_W'(CELL_COUNT - 1);
   localparam logic [CNT_W-1:0] WALK_LAST  = CNT_W'(CELLS_PER_ROW - 1);

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         busy_ff  <= 1'b1;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CLEAR_LAST) begin
                  state_ff <= S_IDLE;
                  cnt_ff   <= '0;
                  busy_ff  <= 1'b0;
               end
            end
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_MUL_C;
                  busy_ff  <= 1'b1;
               end
            end
            S_MUL_C:  state_ff <= S_PROD_C;
            S_PROD_C: state_ff <= S_FIX_C;
            S_FIX_C:  state_ff <= S_MUL_R;
            S_MUL_R:  state_ff <= S_PROD_R;
            S_PROD_R: state_ff <= S_FIX_R;
            S_FIX_R: begin
               state_ff <= S_WALK;
               cnt_ff   <= '0;
            end
            S_WALK: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == WALK_LAST) begin
                  state_ff <= S_DRAIN1;
                  cnt_ff   <= '0;
               end
            end
            S_DRAIN1: state_ff <= S_DRAIN2;
            S_DRAIN2: state_ff <= S_RESULT;
            S_RESULT: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_CLEAR:  cmd.clear_wr = 1'b1;
         S_IDLE:   cmd.latch    = start;
         S_MUL_C:  cmd.red_mul  = 1'b1;
         S_PROD_C: cmd.red_prod = 1'b1;
         S_FIX_C:  cmd.red_fix  = 1'b1;
         S_MUL_R: begin
            cmd.red_mul  = 1'b1;
            cmd.red_row  = 1'b1;
            cmd.store_wr = 1'b1;
         end
         S_PROD_R: begin
            cmd.red_prod = 1'b1;
            cmd.red_row  = 1'b1;
         end
         S_FIX_R: begin
            cmd.red_fix = 1'b1;
            cmd.red_row = 1'b1;
         end
         S_WALK:   cmd.walk_issue = 1'b1;
         S_RESULT: cmd.respond    = 1'b1;
         default:  cmd = '0;
      endcase
   end

   assign busy     = busy_ff;
   assign step_idx = cnt_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/drfi_datapath.sv
// Datapath of the DRAM retention fault injector: request capture, address
// reduction, cell memory, row-walk pipeline and result. Depends on drfi_pkg.
`default_nettype none

module drfi_datapath
   import drfi_pkg::*;
#(
   parameter int CELL_COUNT    = 1024,
   parameter int CELLS_PER_ROW = 16,
   parameter int BITS_PER_CELL = 4,
   localparam int CNT_MAX = (CELL_COUNT > CELLS_PER_ROW) ? CELL_COUNT : CELLS_PER_ROW,
   localparam int CNT_W   = $clog2(CNT_MAX)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   input  wire logic [CNT_W-1:0]    step_idx,
   input  wire logic [DECAY_W-1:0]  refresh_period,
   input  wire logic [DECAY_W-1:0]  decay_threshold,
   input  wire logic [TIME_W-1:0]   time_offset,
   input  wire logic                req_action,
   input  wire logic [ADDR_W-1:0]   req_address,
   input  wire logic [TIME_W-1:0]   req_timestamp,
   input  wire logic [DATA_W-1:0]   req_load_data,
   output logic                     rsp_strobe,
   output logic [DATA_W-1:0]        rsp_result_data
);

   localparam int MW = $clog2(CELL_COUNT);
   localparam int CW = MW + 1;
   localparam int NW = (CW > ADDR_W) ? CW : ADDR_W;
   localparam int WORD_W = TIME_W + DECAY_W;

   localparam logic [31:0] RECIP_CELL = 32'((64'd1 << 32) / CELL_COUNT);
   localparam logic [31:0] RECIP_ROW  = 32'((64'd1 << 32) / CELLS_PER_ROW);
   localparam logic [NW:0] DIV_CELL   = (NW + 1)'(CELL_COUNT);
   localparam logic [NW:0] DIV_ROW    = (NW + 1)'(CELLS_PER_ROW);
   localparam logic [DATA_W-1:0] GROUND_MASK = (64'd1 << BITS_PER_CELL) - 64'd1;

   logic [WORD_W-1:0] mem [CELL_COUNT];

   logic              act_ff;
   logic [TIME_W-1:0] now_ff;
   logic [DATA_W-1:0] data_ff;
   logic [NW-1:0]     red_n_ff;
   logic [NW-1:0]     red_q_ff;
   logic [NW-1:0]     red_p_ff;
   logic [NW-1:0]     cell_ff;
   logic [NW-1:0]     base_ff;
   logic              odd_ff;

   logic [31:0]       recip_sel;
   logic [NW:0]       div_sel;
   logic [NW+31:0]    mul_full;
   logic [2*NW:0]     prod_full;
   logic [NW:0]       red_r;
   logic              red_ge;
   logic [NW:0]       red_rem;

   always_comb begin
      recip_sel = cmd.red_row ? RECIP_ROW : RECIP_CELL;
      div_sel   = cmd.red_row ? DIV_ROW : DIV_CELL;
      mul_full  = (NW + 32)'(red_n_ff) * (NW + 32)'(recip_sel);
      prod_full = (2 * NW + 1)'(red_q_ff) * (2 * NW + 1)'(div_sel);
      red_r     = {1'b0, red_n_ff} - {1'b0, red_p_ff};
      red_ge    = red_r >= div_sel;
      red_rem   = red_ge ? red_r - div_sel : red_r;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff   <= req_action;
         now_ff   <= req_timestamp - time_offset;
         data_ff  <= req_load_data;
         red_n_ff <= NW'(req_address);
      end
      if (cmd.red_mul) begin
         red_q_ff <= mul_full[NW+31:32];
      end
      if (cmd.red_prod) begin
         red_p_ff <= prod_full[NW-1:0];
      end
      if (cmd.red_fix) begin
         if (cmd.red_row) begin
            base_ff <= cell_ff - red_rem[NW-1:0];
            odd_ff  <= red_q_ff[0] ^ red_ge;
         end else begin
            cell_ff  <= red_rem[NW-1:0];
            red_n_ff <= red_rem[NW-1:0];
         end
      end
   end

   logic [NW:0]         walk_e;
   logic                walk_in_range;
   logic                walk_tgt;

   logic                v1_ff;
   logic [MW-1:0]       a1_ff;
   logic                t1_ff;
   logic [WORD_W-1:0]   rd_word_ff;

   logic                v2_ff;
   logic [MW-1:0]       a2_ff;
   logic                t2_ff;
   logic [TIME_W-1:0]   gap_ff;
   logic                upd_ff;
   logic [DECAY_W-1:0]  dec2_ff;

   logic [TIME_W-1:0]   rd_stamp;
   logic [DECAY_W-1:0]  rd_decay;
   logic [TIME_W-1:0]   gap_in;
   logic [DECAY_W-1:0]  new_decay;
   logic [DECAY_W-1:0]  tdec_ff;

   logic                wr_en;
   logic [MW-1:0]       wr_idx;
   logic [WORD_W-1:0]   wr_word;

   always_comb begin
      walk_e        = {1'b0, base_ff} + (NW + 1)'(step_idx);
      walk_in_range = walk_e < DIV_CELL;
      walk_tgt      = walk_e == {1'b0, cell_ff};
      rd_stamp      = rd_word_ff[WORD_W-1:DECAY_W];
      rd_decay      = rd_word_ff[DECAY_W-1:0];
      gap_in        = now_ff - rd_stamp;
      new_decay     = (gap_ff > TIME_W'(refresh_period)) ? refresh_period
                                                         : gap_ff[DECAY_W-1:0];
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = a2_ff;
      wr_word = {now_ff, new_decay};
      if (cmd.clear_wr) begin
         wr_en   = 1'b1;
         wr_idx  = step_idx[MW-1:0];
         wr_word = '0;
      end else if (cmd.store_wr && act_ff == ACT_STORE) begin
         wr_en   = 1'b1;
         wr_idx  = cell_ff[MW-1:0];
         wr_word = {now_ff, {DECAY_W{1'b0}}};
      end else if (v2_ff && upd_ff) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_issue && walk_in_range) begin
         rd_word_ff <= mem[walk_e[MW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.walk_issue && walk_in_range;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff   <= walk_e[MW-1:0];
      t1_ff   <= walk_tgt;
      a2_ff   <= a1_ff;
      t2_ff   <= t1_ff;
      gap_ff  <= gap_in;
      upd_ff  <= gap_in > TIME_W'(rd_decay);
      dec2_ff <= rd_decay;
      if (v2_ff && t2_ff) begin
         tdec_ff <= upd_ff ? new_decay : dec2_ff;
      end
   end

   logic              grounded;
   logic [DATA_W-1:0] load_out;

   always_comb begin
      grounded = tdec_ff >= decay_threshold;
      load_out = data_ff;
      if (grounded) begin
         load_out = (data_ff & ~GROUND_MASK) | (odd_ff ? '0 : GROUND_MASK);
      end
   end

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         rsp_data_ff <= (act_ff == ACT_LOAD) ? load_out : '0;
      end
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_result_data = rsp_data_ff;

   a_drained_at_result: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> !v1_ff && !v2_ff)
      else $error("row walk still in flight at result");

endmodule

`default_nettype wire

FILE: hw/rtl/dram_retention_fault_injector_unit.sv
// Top level of the DRAM retention fault injector: control registers, sequencer
// and datapath. Depends on drfi_pkg, drfi_ctrl and drfi_datapath.
//
// Usage:
//   Request: drive req_action (0 store, 1 load), req_address, req_timestamp and
//   req_load_data with start high; the request is taken at a rising edge where
//   start is high and busy is low.
//   Response: rsp_strobe is high for one cycle with rsp_result_data; the receiver
//   cannot stall, so every response must be taken in that cycle.
//   Control: csr_write_enable with csr_index and csr_write_data writes refresh
//   period (0), decay threshold (1) or time offset (2); write only while idle.
//   Sequence: the response follows the address reduction, the row walk and the
//   drain states, and busy falls in the same cycle as rsp_strobe rises, so a
//   new request is taken only after the previous response. The row walk visits
//   one cell per cycle, reading the cell memory while the update pipeline
//   writes back earlier cells through the separate write port.
//   Reset: synchronous; control registers return to their defaults and a
//   clearing pass over all CELL_COUNT cells zeroes the cell memory, with busy high.
`default_nettype none

module dram_retention_fault_injector_unit
   import drfi_pkg::*;
#(
   parameter int CELL_COUNT    = 1024,
   parameter int CELLS_PER_ROW = 16,
   parameter int BITS_PER_CELL = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_action,
   input  wire logic [ADDR_W-1:0]      req_address,
   input  wire logic [TIME_W-1:0]      req_timestamp,
   input  wire logic [DATA_W-1:0]      req_load_data,
   output logic                        rsp_strobe,
   output logic [DATA_W-1:0]           rsp_result_data,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CNT_MAX = (CELL_COUNT > CELLS_PER_ROW) ? CELL_COUNT : CELLS_PER_ROW;
   localparam int CNT_W   = $clog2(CNT_MAX);

   logic [DECAY_W-1:0] refresh_period_ff;
   logic [DECAY_W-1:0] decay_threshold_ff;
   logic [TIME_W-1:0]  time_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_period_ff  <= REFRESH_PERIOD_RST;
         decay_threshold_ff <= DECAY_THRESHOLD_RST;
         time_offset_ff     <= TIME_OFFSET_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_REFRESH_PERIOD:  refresh_period_ff  <= csr_write_data[DECAY_W-1:0];
            CSR_DECAY_THRESHOLD: decay_threshold_ff <= csr_write_data[DECAY_W-1:0];
            CSR_TIME_OFFSET:     time_offset_ff     <= csr_write_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   dp_cmd_type       cmd;
   logic [CNT_W-1:0] step_idx;

   drfi_ctrl #(
      .CELL_COUNT    (CELL_COUNT),
      .CELLS_PER_ROW (CELLS_PER_ROW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .cmd      (cmd),
      .step_idx (step_idx)
   );

   drfi_datapath #(
      .CELL_COUNT    (CELL_COUNT),
      .CELLS_PER_ROW (CELLS_PER_ROW),
      .BITS_PER_CELL (BITS_PER_CELL)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .step_idx        (step_idx),
      .refresh_period  (refresh_period_ff),
      .decay_threshold (decay_threshold_ff),
      .time_offset     (time_offset_ff),
      .req_action      (req_action),
      .req_address     (req_address),
      .req_timestamp   (req_timestamp),
      .req_load_data   (req_load_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_data (rsp_result_data)
   );

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken without going busy");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a request in progress");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

endmodule

`default_nettype wire

FILE: tb/drfi_checker.sv
`timescale 1ns / 100ps
// Response checker for dram_retention_fault_injector_unit: tracks per-cell refresh
// stamps and decay, predicts each response and compares it. Depends on drfi_pkg.

module drfi_checker
   import drfi_pkg::*;
#(
   parameter int CELL_COUNT    = 1024,
   parameter int CELLS_PER_ROW = 16,
   parameter int BITS_PER_CELL = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic                  req_action,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [TIME_W-1:0]     req_timestamp,
   input  logic [DATA_W-1:0]     req_load_data,
   input  logic                  rsp_strobe,
   input  logic [DATA_W-1:0]     rsp_result_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    mismatch_count,
   output int                    results_outstanding
);

   logic [TIME_W-1:0]  cell_stamp [CELL_COUNT];
   logic [DECAY_W-1:0] cell_decay [CELL_COUNT];
   logic [DECAY_W-1:0] cap_period;
   logic [DECAY_W-1:0] ground_threshold;
   logic [TIME_W-1:0]  offset_ticks;
   logic [DATA_W-1:0]  pending_results [$];
   logic [DATA_W-1:0]  oldest_result;

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] wanted,
                                  input logic [DATA_W-1:0] seen);
      $display("%0t mismatch: %s, expected %h, got %h", $time, what, wanted, seen);
      mismatch_count++;
   endtask

   function automatic void refresh_row(input int cell_idx, input logic [TIME_W-1:0] now);
      int base;
      int c;
      int k;
      logic [TIME_W-1:0] gap;
      base = (cell_idx / CELLS_PER_ROW) * CELLS_PER_ROW;
      for (k = 0; k < CELLS_PER_ROW; k++) begin
         c = base + k;
         if (c >= CELL_COUNT) break;
         gap = now - cell_stamp[c];
         if (gap > TIME_W'(cell_decay[c])) begin
            cell_stamp[c] = now;
            cell_decay[c] = (gap > TIME_W'(cap_period)) ? cap_period : gap[DECAY_W-1:0];
         end
      end
   endfunction

   function automatic logic [DATA_W-1:0] decayed_result(input logic act,
                                                        input logic [ADDR_W-1:0] addr,
                                                        input logic [TIME_W-1:0] stamp,
                                                        input logic [DATA_W-1:0] data);
      int cell_idx;
      logic [TIME_W-1:0] now;
      logic [DATA_W-1:0] ground_mask;
      logic [DATA_W-1:0] value;
      cell_idx = int'(addr) % CELL_COUNT;
      now = stamp - offset_ticks;
      if (act == ACT_STORE) begin
         cell_stamp[cell_idx] = now;
         cell_decay[cell_idx] = '0;
         refresh_row(cell_idx, now);
         return '0;
      end
      refresh_row(cell_idx, now);
      value = data;
      if (cell_decay[cell_idx] >= ground_threshold) begin
         ground_mask = (64'd1 << BITS_PER_CELL) - 64'd1;
         value = value & ~ground_mask;
         if (((cell_idx / CELLS_PER_ROW) % 2) == 0) value = value | ground_mask;
      end
      return value;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cap_period       = REFRESH_PERIOD_RST;
         ground_threshold = DECAY_THRESHOLD_RST;
         offset_ticks     = TIME_OFFSET_RST;
         for (int i = 0; i < CELL_COUNT; i++) begin
            cell_stamp[i] = '0;
            cell_decay[i] = '0;
         end
         pending_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with no request waiting", '0, rsp_result_data);
            end else begin
               oldest_result = pending_results.pop_front();
               if (rsp_result_data !== oldest_result)
                  report_mismatch("result_data", oldest_result, rsp_result_data);
            end
         end
         if (start && !busy)
            pending_results.push_back(decayed_result(req_action, req_address,
                                                     req_timestamp, req_load_data));
         if (csr_write_enable) begin
            case (csr_index)
               CSR_REFRESH_PERIOD:  cap_period       = csr_write_data[DECAY_W-1:0];
               CSR_DECAY_THRESHOLD: ground_threshold = csr_write_data[DECAY_W-1:0];
               CSR_TIME_OFFSET:     offset_ticks     = csr_write_data[TIME_W-1:0];
               default: ;
            endcase
         end
      end
      results_outstanding <= pending_results.size();
   end

endmodule

FILE: tb/tb_dram_retention_fault_injector_unit.sv
`timescale 1ns / 100ps
// Top of the testbench for dram_retention_fault_injector_unit: clock, reset, CSR
// settings and request stimulus; checking lives in drfi_checker. Depends on drfi_pkg.

module tb_dram_retention_fault_injector_unit;
   import drfi_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 175;
   localparam int PHASE_COUNT = 6;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_action;
   logic [ADDR_W-1:0]     req_address;
   logic [TIME_W-1:0]     req_timestamp;
   logic [DATA_W-1:0]     req_load_data;
   logic                  rsp_strobe;
   logic [DATA_W-1:0]     rsp_result_data;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    mismatch_count;
   int                    results_outstanding;

   int                    cycle_count;
   int                    idle_pct;
   int                    hot_row [3];
   int unsigned           step_max;
   logic [TIME_W-1:0]     time_cursor;
   logic [TIME_W-1:0]     offset_now;
   logic [DECAY_W-1:0]    period_now;

   dram_retention_fault_injector_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_address      (req_address),
      .req_timestamp    (req_timestamp),
      .req_load_data    (req_load_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_data  (rsp_result_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   drfi_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_address         (req_address),
      .req_timestamp       (req_timestamp),
      .req_load_data       (req_load_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_data     (rsp_result_data),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // call at a falling edge; returns at the falling edge after the request is taken
   task automatic send_request(input logic act, input logic [ADDR_W-1:0] addr,
                               input logic [TIME_W-1:0] stamp,
                               input logic [DATA_W-1:0] data);
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start         = 1'b1;
      req_action    = act;
      req_address   = addr;
      req_timestamp = stamp;
      req_load_data = data;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start = 1'b0;
      while (results_outstanding != 0) @(negedge clock);
   endtask

   task automatic write_settings(input logic [DECAY_W-1:0] period,
                                 input logic [DECAY_W-1:0] threshold,
                                 input logic [TIME_W-1:0] offset);
      period_now    = period;
      offset_now    = offset;
      step_max      = (period > 100_000_000) ? 200_000_000 : period * 2 + 2;
      csr_write_enable = 1'b1;
      csr_index        = CSR_REFRESH_PERIOD;
      csr_write_data   = {16'd0, period};
      @(negedge clock);
      csr_index        = CSR_DECAY_THRESHOLD;
      csr_write_data   = {16'd0, threshold};
      @(negedge clock);
      csr_index        = CSR_TIME_OFFSET;
      csr_write_data   = offset;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // mostly accesses to a few hot rows along an advancing clock; the rest is noise
   task automatic random_request();
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] stamp;
      logic [63:0]       raw;
      raw = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 15) begin
         addr  = ADDR_W'($urandom);
         stamp = raw[TIME_W-1:0];
      end else begin
         if ($urandom_range(0, 3) != 0) time_cursor = time_cursor + $urandom_range(0, step_max);
         addr  = {6'(hot_row[$urandom_range(0, 2)]), 4'($urandom_range(0, 15))};
         stamp = time_cursor + offset_now;
      end
      send_request(1'($urandom_range(0, 1)), addr, stamp, {$urandom, $urandom});
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_action       = ACT_STORE;
      req_address      = '0;
      req_timestamp    = '0;
      req_load_data    = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_REFRESH_PERIOD;
      csr_write_data   = '0;
      idle_pct         = 35;
      time_cursor      = '0;
      offset_now       = '0;
      period_now       = REFRESH_PERIOD_RST;
      step_max         = 200_000_000;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: store/load round trips, grounding on even and odd rows
      send_request(ACT_STORE, 10'd0, 48'd0, '1);
      send_request(ACT_LOAD, 10'd0, 48'd0, '1);
      send_request(ACT_LOAD, 10'd1023, 48'hFFFF_FFFF_FFFF, '1);
      send_request(ACT_LOAD, 10'd17, 48'd40_000_000, {$urandom, $urandom});
      send_request(ACT_LOAD, 10'd34, 48'd40_000_000, '0);
      send_request(ACT_LOAD, 10'd34, 48'd40_000_010, '0);
      send_request(ACT_STORE, 10'd34, 48'd50_000_000, {$urandom, $urandom});
      send_request(ACT_LOAD, 10'd34, 48'd50_001_000, '0);
      send_request(ACT_LOAD, 10'd34, 48'd10, '1);
      drain_results();

      // zero refresh period, zero threshold, offset that wraps the time
      write_settings('0, '0, 48'hFFFF_FFFF_FFFF);
      send_request(ACT_LOAD, 10'd5, 48'd3, '1);
      send_request(ACT_STORE, 10'd5, 48'd0, '1);
      send_request(ACT_LOAD, 10'd5, 48'd0, '1);
      send_request(ACT_LOAD, 10'd500, 48'h8000_0000_0000, '0);
      drain_results();

      // widest period and threshold
      write_settings('1, '1, 48'd1);
      send_request(ACT_LOAD, 10'd100, 48'd0, '0);
      send_request(ACT_STORE, 10'd101, 48'd7, '1);
      send_request(ACT_LOAD, 10'd101, 48'h7FFF_FFFF_0000, '1);
      send_request(ACT_LOAD, 10'd1023, 48'h1_0000_0000, '0);
      send_request(ACT_LOAD, 10'd1008, 48'hFFFF_FFFF_FFFF, '1);
      drain_results();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: write_settings(32'd1000, 32'd500, TIME_W'({$urandom, $urandom}));
            1: begin
               period_now = $urandom_range(1, 5000);
               write_settings(period_now, $urandom_range(0, period_now + 100),
                              TIME_W'({$urandom, $urandom}));
            end
            2: write_settings('1, '0, '0);
            3: write_settings(32'd1, 32'd1, 48'hFFFF_FFFF_FFFF);
            4: write_settings(REFRESH_PERIOD_RST, DECAY_THRESHOLD_RST,
                              TIME_W'({$urandom, $urandom}));
            default: write_settings($urandom, $urandom, TIME_W'({$urandom, $urandom}));
         endcase
         idle_pct = (phase < 2) ? 35 : (phase < 4) ? 85 : 0;
         for (int i = 0; i < 3; i++) hot_row[i] = $urandom_range(0, 63);
         time_cursor = TIME_W'({$urandom, $urandom});
         repeat (PHASE_ITEMS) random_request();
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/drfi_pkg.sv
hw/rtl/drfi_ctrl.sv
hw/rtl/drfi_datapath.sv
hw/rtl/dram_retention_fault_injector_unit.sv
tb/drfi_checker.sv
tb/tb_dram_retention_fault_injector_unit.sv
